// ===== rtl/bisa_pkg.sv =====
// Shared types, constants and bit helpers for the bitmap inode and sector allocator.
// No dependencies; the top level and the checker import this package.
package bisa_pkg;

    localparam int SECTOR_BYTES           = 512;
    localparam int MAX_INODE_MAP_SECTORS  = 1;
    localparam int MAX_SECTOR_MAP_SECTORS = 16;

    localparam int IMAP_BYTES = MAX_INODE_MAP_SECTORS * SECTOR_BYTES;
    localparam int SMAP_BYTES = MAX_SECTOR_MAP_SECTORS * SECTOR_BYTES;
    localparam int IMAP_AW    = $clog2(IMAP_BYTES);
    localparam int SMAP_AW    = $clog2(SMAP_BYTES);
    localparam int MAP_AW     = (SMAP_AW > IMAP_AW) ? SMAP_AW : IMAP_AW;
    localparam int MAP_CW     = MAP_AW + 1;
    localparam int BIT_W      = MAP_AW + 3;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 13;
    localparam int RUN_W  = 17;
    localparam int ID_W   = 25;
    localparam int ST_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W  = 24;

    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_INODE = 2'd0,
        MODE_LOAD_SECT  = 2'd1,
        MODE_ALLOC_INODE = 2'd2,
        MODE_ALLOC_SECT = 2'd3
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_RUN  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INODE_MAP_SECTORS  = 2'd0,
        CFG_SECTOR_MAP_SECTORS = 2'd1,
        CFG_FIRST_DATA_SECTOR  = 2'd2,
        CFG_UNUSED             = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  byte_index;
        logic [7:0]        byte_value;
        logic [RUN_W-1:0]  run_length;
    } t_alloc_req;

    typedef struct packed {
        logic [ID_W-1:0] allocated_id;
        logic [ST_W-1:0] status;
    } t_alloc_rsp;

    // Position of the lowest clear bit; caller knows one exists.
    function automatic logic [2:0] low_clear(input logic [7:0] v);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!v[i]) k = 3'(i);
        end
        return k;
    endfunction

    // Position of the first set bit at or above s, 8 if none.
    function automatic logic [3:0] first_set_from(input logic [7:0] v, input logic [2:0] s);
        logic [3:0] f;
        f = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (v[i] && (i >= int'(s))) f = 4'(i);
        end
        return f;
    endfunction

    // n ones starting at bit s.
    function automatic logic [7:0] run_mask(input logic [2:0] s, input logic [3:0] n);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (i >= int'(s)) && (i < int'(s) + int'(n));
        end
        return m;
    endfunction

endpackage

// ===== rtl/bisa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
module bisa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/bitmap_inode_and_sector_allocator_top.sv =====
// Bitmap allocator top level: inode map and sector map in two byte RAMs, first-fit search.
// Depends on bisa_pkg and bisa_ram.
//
// Usage: one item is taken when start is high and busy is low. A byte load's result strobes
// on o_done in the next cycle; a load may follow every cycle. An allocation scans its map
// one byte per cycle through the RAM read port and keeps busy high until its result strobes;
// it reads the bytes up to and including the first byte with a clear bit (up to 8192 bytes at
// 16 sectors of 512 bytes for the sector map). A sector run then marks, in turn, each map
// byte it touches. The result is shown on o_done/o_rsp for exactly one cycle and cannot be
// held off. The maps have no reset contents: load every byte an allocation may scan before
// allocating. Configuration writes take effect at once, so write only while busy is low and
// no result is pending.
module bitmap_inode_and_sector_allocator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bisa_pkg::t_alloc_req                i_req,
    output logic                                o_done,
    output bisa_pkg::t_alloc_rsp                o_rsp,
    input  logic                                i_cfg_we,
    input  logic [bisa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bisa_pkg::CFG_W-1:0]          i_cfg_data
);
    import bisa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RUN
    } t_state;

    t_state              r_state, n_state;
    logic                r_done, n_done;
    t_alloc_rsp          r_rsp, n_rsp;

    logic                r_cfg_imap;
    logic [4:0]          r_cfg_smap;
    logic [CFG_W-1:0]    r_cfg_fds;

    logic [MAP_CW-1:0]   r_ra, n_ra;
    logic                r_rv, n_rv;
    logic [MAP_AW-1:0]   r_rn, n_rn;
    logic                r_is_inode, n_is_inode;
    logic [7:0]          r_byte, n_byte;
    logic [2:0]          r_s, n_s;
    logic [MAP_AW-1:0]   r_n, n_n;
    logic [BIT_W-1:0]    r_b, n_b;
    logic [RUN_W-1:0]    r_left, n_left;
    logic                r_src_ram, n_src_ram;

    logic [MAP_CW-1:0]   imap_bytes, smap_bytes, nbytes, idle_nbytes;
    logic [MAP_AW-1:0]   ram_raddr, ram_waddr;
    logic [7:0]          ram_wdata, rd_inode, rd_sect, rd_byte;
    logic                we_inode, we_sect;
    logic                accept;

    logic [2:0]          scan_k;
    logic [7:0]          cur_byte;
    logic [2:0]          cur_s;
    logic [3:0]          cur_f, avail, take;
    logic [RUN_W-1:0]    left_after;
    logic [MAP_AW-1:0]   n_plus1;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Map sizes in bytes, counts above the maximum clamp to it.
    always_comb begin
        if (int'(r_cfg_imap) > MAX_INODE_MAP_SECTORS) begin
            imap_bytes = MAP_CW'(IMAP_BYTES);
        end else begin
            imap_bytes = MAP_CW'(int'(r_cfg_imap) * SECTOR_BYTES);
        end
        if (int'(r_cfg_smap) > MAX_SECTOR_MAP_SECTORS) begin
            smap_bytes = MAP_CW'(SMAP_BYTES);
        end else begin
            smap_bytes = MAP_CW'(int'(r_cfg_smap) * SECTOR_BYTES);
        end
    end

    assign nbytes      = r_is_inode ? imap_bytes : smap_bytes;
    assign idle_nbytes = (t_mode'(i_req.mode) == MODE_ALLOC_INODE) ? imap_bytes : smap_bytes;
    assign rd_byte     = r_is_inode ? rd_inode : rd_sect;
    assign scan_k      = low_clear(rd_byte);
    assign n_plus1     = r_n + MAP_AW'(1);

    // One step of a sector run over the current byte.
    always_comb begin
        cur_byte   = r_src_ram ? rd_sect : r_byte;
        cur_s      = r_src_ram ? 3'd0 : r_s;
        cur_f      = first_set_from(cur_byte, cur_s);
        avail      = cur_f - {1'b0, cur_s};
        take       = (r_left < RUN_W'(avail)) ? r_left[3:0] : avail;
        left_after = r_left - RUN_W'(take);
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        n_ra       = r_ra;
        n_rv       = 1'b0;
        n_rn       = r_rn;
        n_is_inode = r_is_inode;
        n_byte     = r_byte;
        n_s        = r_s;
        n_n        = r_n;
        n_b        = r_b;
        n_left     = r_left;
        n_src_ram  = r_src_ram;
        ram_raddr  = r_ra[MAP_AW-1:0];
        ram_waddr  = r_rn;
        ram_wdata  = rd_byte;
        we_inode   = 1'b0;
        we_sect    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rsp.allocated_id = '0;
                    n_rsp.status       = ST_OK;
                    n_is_inode         = (t_mode'(i_req.mode) == MODE_ALLOC_INODE);
                    n_left             = i_req.run_length;
                    n_ra               = '0;
                    ram_waddr          = MAP_AW'(i_req.byte_index);
                    ram_wdata          = i_req.byte_value;
                    unique case (t_mode'(i_req.mode))
                        MODE_LOAD_INODE: begin
                            we_inode = (int'(i_req.byte_index) < IMAP_BYTES);
                            n_done   = 1'b1;
                        end
                        MODE_LOAD_SECT: begin
                            we_sect = (int'(i_req.byte_index) < SMAP_BYTES);
                            n_done  = 1'b1;
                        end
                        MODE_ALLOC_INODE, MODE_ALLOC_SECT: begin
                            if ((t_mode'(i_req.mode) == MODE_ALLOC_SECT)
                                && (i_req.run_length == '0)) begin
                                n_done = 1'b1;
                            end else if (idle_nbytes == '0) begin
                                n_rsp.status = ST_FULL;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                // Read one byte a cycle; the RAM returns it on its registered read port.
                n_rv = (r_ra < nbytes);
                n_rn = r_ra[MAP_AW-1:0];
                n_ra = r_ra + MAP_CW'(1);
                if (r_rv) begin
                    if (rd_byte != BYTE_FULL) begin
                        if (r_is_inode) begin
                            we_inode           = 1'b1;
                            ram_wdata          = rd_byte | (8'd1 << scan_k);
                            n_rsp.allocated_id = ID_W'({r_rn, scan_k});
                            n_done             = 1'b1;
                            n_state            = S_IDLE;
                        end else begin
                            n_byte    = rd_byte;
                            n_s       = scan_k;
                            n_n       = r_rn;
                            n_b       = {r_rn, scan_k};
                            n_src_ram = 1'b0;
                            n_state   = S_RUN;
                        end
                    end else if ((MAP_CW'(r_rn) + MAP_CW'(1)) == nbytes) begin
                        n_rsp.status = ST_FULL;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_RUN: begin
                we_sect   = 1'b1;
                ram_waddr = r_n;
                ram_wdata = cur_byte | run_mask(cur_s, take);
                ram_raddr = n_plus1;
                n_left    = left_after;
                if (left_after == '0) begin
                    n_rsp.allocated_id = ID_W'(r_b) + ID_W'(r_cfg_fds) - ID_W'(1);
                    n_done             = 1'b1;
                    n_state            = S_IDLE;
                end else if ((cur_f != 4'd8) || ((MAP_CW'(r_n) + MAP_CW'(1)) == nbytes)) begin
                    // Hit a used bit or the map end; marks made so far stay.
                    n_rsp.status = ST_RUN;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_n       = n_plus1;
                    n_src_ram = 1'b1;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_rv       <= 1'b0;
            r_cfg_imap <= 1'b1;
            r_cfg_smap <= 5'd16;
            r_cfg_fds  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_rsp   <= n_rsp;
            r_rv    <= n_rv;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_INODE_MAP_SECTORS:  r_cfg_imap <= i_cfg_data[0];
                    CFG_SECTOR_MAP_SECTORS: r_cfg_smap <= i_cfg_data[4:0];
                    CFG_FIRST_DATA_SECTOR:  r_cfg_fds  <= i_cfg_data;
                    CFG_UNUSED:             ;
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra       <= n_ra;
        r_rn       <= n_rn;
        r_is_inode <= n_is_inode;
        r_byte     <= n_byte;
        r_s        <= n_s;
        r_n        <= n_n;
        r_b        <= n_b;
        r_left     <= n_left;
        r_src_ram  <= n_src_ram;
    end

    bisa_ram #(
        .WIDTH (8),
        .DEPTH (IMAP_BYTES)
    ) u_inode_ram (
        .i_clk   (i_clk),
        .i_we    (we_inode),
        .i_waddr (ram_waddr[IMAP_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[IMAP_AW-1:0]),
        .o_rdata (rd_inode)
    );

    bisa_ram #(
        .WIDTH (8),
        .DEPTH (SMAP_BYTES)
    ) u_sector_ram (
        .i_clk   (i_clk),
        .i_we    (we_sect),
        .i_waddr (ram_waddr[SMAP_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[SMAP_AW-1:0]),
        .o_rdata (rd_sect)
    );

endmodule

// ===== rtl/bisa_checker.sv =====
// Port-level checks for the bitmap allocator top level, attached by bind.
// Depends on bisa_pkg.
module bisa_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input bisa_pkg::t_alloc_req   i_req,
    input logic                   o_done,
    input bisa_pkg::t_alloc_rsp   o_rsp
);
    import bisa_pkg::*;

    // A load answers in the next cycle.
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_req.mode == MODE_LOAD_INODE) || (i_req.mode == MODE_LOAD_SECT)))
        |=> (o_done && (o_rsp.status == ST_OK) && (o_rsp.allocated_id == '0)))
        else $error("load transfer did not answer next cycle");

    // A failed request never reports an id.
    a_err_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_OK)) |-> (o_rsp.allocated_id == '0))
        else $error("nonzero id with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_rsp.status == ST_OK) || (o_rsp.status == ST_FULL)
                    || (o_rsp.status == ST_RUN)))
        else $error("undefined status code");

    // The result strobe comes when the block has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind bitmap_inode_and_sector_allocator_top bisa_checker u_bisa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
